>>> rtl/conv2d_forward_nhwc_defines.svh
// Assertion macros used by the convolution top level.
`ifndef CONV2D_FORWARD_NHWC_DEFINES_SVH
`define CONV2D_FORWARD_NHWC_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define C2D_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define C2D_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/c2d_pkg.sv
// Shared constants and types for the convolution block.
`default_nettype none
package c2d_pkg;
	localparam int MAX_WIDTH = 128;
	localparam int MAX_IN_CHANNELS = 16;
	localparam int MAX_KERNEL = 8;
	localparam int MAX_OUT_CHANNELS = 64;

	localparam int VAL_W = 16;
	localparam int SUM_W = 48;
	localparam int WADDR_W = 16;
	localparam int LADDR_W = 14;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd7;

	typedef struct packed {
		logic issue;
		logic last_term;
		logic clear;
	} mac_ctl_t;
endpackage
`default_nettype wire

>>> rtl/c2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module c2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/c2d_div.sv
// Two-lane restoring divider that finds window row and column indexes by the stride.
`default_nettype none
module c2d_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] dvd_y,
	input  wire logic [15:0] dvd_x,
	input  wire logic [3:0]  dvs,
	output logic             done,
	output logic [15:0]      quo_y,
	output logic [15:0]      quo_x,
	output logic             rem_zero_y,
	output logic             rem_zero_x
);
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [3:0]  dvs_q;
	logic [15:0] qy_q, qx_q;
	logic [3:0]  ry_q, rx_q;
	logic [4:0]  sh_y, sh_x;
	logic        ge_y, ge_x;
	logic [4:0]  dif_y, dif_x;

	always_comb begin
		sh_y = {ry_q, qy_q[15]};
		sh_x = {rx_q, qx_q[15]};
		ge_y = sh_y >= {1'b0, dvs_q};
		ge_x = sh_x >= {1'b0, dvs_q};
		dif_y = sh_y - {1'b0, dvs_q};
		dif_x = sh_x - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qy_q <= dvd_y;
			qx_q <= dvd_x;
			ry_q <= '0;
			rx_q <= '0;
			dvs_q <= dvs;
		end else if (busy_q) begin
			qy_q <= {qy_q[14:0], ge_y};
			qx_q <= {qx_q[14:0], ge_x};
			ry_q <= ge_y ? dif_y[3:0] : sh_y[3:0];
			rx_q <= ge_x ? dif_x[3:0] : sh_x[3:0];
		end
	end

	assign done = done_q;
	assign quo_y = qy_q;
	assign quo_x = qx_q;
	assign rem_zero_y = (ry_q == 4'd0);
	assign rem_zero_x = (rx_q == 4'd0);
endmodule
`default_nettype wire

>>> rtl/c2d_mac.sv
// Pipelined multiply-accumulate unit shared by every product of a window.
`default_nettype none
module c2d_mac (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire c2d_pkg::mac_ctl_t            ctl,
	input  wire logic signed [c2d_pkg::VAL_W-1:0] wdata,
	input  wire logic signed [c2d_pkg::VAL_W-1:0] ldata,
	output logic signed [c2d_pkg::SUM_W-1:0]  acc,
	output logic                              done
);
	logic              vld_s1, last_s1;
	logic              vld_s2, last_s2;
	logic signed [31:0] prod_s2;
	logic signed [c2d_pkg::SUM_W-1:0] acc_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			last_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
			last_s1 <= ctl.issue & ctl.last_term;
			vld_s2 <= vld_s1;
			last_s2 <= last_s1;
			done_q <= vld_s2 & last_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= wdata * ldata;
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + {{(c2d_pkg::SUM_W-32){prod_s2[31]}}, prod_s2};
		end
	end

	assign acc = acc_q;
	assign done = done_q;
endmodule
`default_nettype wire

>>> rtl/conv2d_forward_nhwc.sv
// Top level of the strided 2D convolution with weight and line stores.
// A weight word goes straight into the weight store. A pixel word that cannot
// complete a window leaves the block ready; when it may, a 16-step divider by
// the stride runs first, and each output channel of a completed window is then
// summed by the single multiply-accumulate unit, which reads one weight and one
// line store entry a cycle while it sums.
// Results wait in an output register, so the block moves on while one is held.
// The stores are not cleared after reset; weights must be loaded before use.
`default_nettype none
`include "conv2d_forward_nhwc_defines.svh"
module conv2d_forward_nhwc (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  mode,
	input  wire logic signed [15:0]    value,
	input  wire logic                  last,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [47:0]         sum_value,
	output logic [5:0]                 channel,
	output logic                       window_last,
	output logic                       sample_done,
	input  wire logic                  cfg_we,
	input  wire logic [c2d_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [c2d_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_MAC  = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [7:0] iw_q, oh_q, ow_q;
	logic [4:0] ic_q;
	logic [3:0] kh_q, kw_q, st_q;
	logic [6:0] oc_q;
	logic [7:0] iw_e, oh_e, ow_e;
	logic [4:0] ic_e;
	logic [3:0] kh_e, kw_e, st_e;
	logic [6:0] oc_e;

	logic [15:0] row_q;
	logic [6:0]  col_q;
	logic [3:0]  chan_q;
	logic [6:0]  col_e;
	logic [3:0]  chan_e;
	logic [15:0] wptr_q;

	logic        acc_in, pix_acc, cand;
	logic [16:0] row_p1;
	logic [7:0]  col_p1;
	logic [4:0]  chan_p1;
	logic [15:0] dy;
	logic [6:0]  dx;
	logic [2:0]  dy3_q;
	logic [6:0]  dx_q;
	logic        final_q;

	logic        div_done, rz_y, rz_x;
	logic [15:0] q_y, q_x;
	logic        win_ok;

	logic [5:0]  co_q;
	logic [2:0]  r_q, c_q;
	logic [3:0]  ci_q;
	logic [15:0] waddr_q;
	logic        last_term, co_last, emit_load;
	logic [2:0]  lrow;
	logic [6:0]  lcol;
	logic [15:0] w_rd, l_rd;
	c2d_pkg::mac_ctl_t ctl;
	logic signed [47:0] acc;
	logic        mac_done;

	logic        out_vld_q;

	always_comb begin
		iw_e = (iw_q == 8'd0) ? 8'd1 : (iw_q > 8'(c2d_pkg::MAX_WIDTH)) ?
			8'(c2d_pkg::MAX_WIDTH) : iw_q;
		ic_e = (ic_q == 5'd0) ? 5'd1 : (ic_q > 5'(c2d_pkg::MAX_IN_CHANNELS)) ?
			5'(c2d_pkg::MAX_IN_CHANNELS) : ic_q;
		kh_e = (kh_q == 4'd0) ? 4'd1 : (kh_q > 4'(c2d_pkg::MAX_KERNEL)) ?
			4'(c2d_pkg::MAX_KERNEL) : kh_q;
		kw_e = (kw_q == 4'd0) ? 4'd1 : (kw_q > 4'(c2d_pkg::MAX_KERNEL)) ?
			4'(c2d_pkg::MAX_KERNEL) : kw_q;
		oc_e = (oc_q == 7'd0) ? 7'd1 : (oc_q > 7'(c2d_pkg::MAX_OUT_CHANNELS)) ?
			7'(c2d_pkg::MAX_OUT_CHANNELS) : oc_q;
		oh_e = (oh_q == 8'd0) ? 8'd1 : oh_q;
		ow_e = (ow_q == 8'd0) ? 8'd1 : ow_q;
		st_e = (st_q == 4'd0) ? 4'd1 : st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q <= 8'd1;
			ic_q <= 5'd1;
			kh_q <= 4'd1;
			kw_q <= 4'd1;
			oc_q <= 7'd1;
			oh_q <= 8'd1;
			ow_q <= 8'd1;
			st_q <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				c2d_pkg::REG_IN_WIDTH: iw_q <= cfg_data;
				c2d_pkg::REG_IN_CHANNELS: ic_q <= cfg_data[4:0];
				c2d_pkg::REG_KERNEL_HEIGHT: kh_q <= cfg_data[3:0];
				c2d_pkg::REG_KERNEL_WIDTH: kw_q <= cfg_data[3:0];
				c2d_pkg::REG_OUT_CHANNELS: oc_q <= cfg_data[6:0];
				c2d_pkg::REG_OUT_HEIGHT: oh_q <= cfg_data;
				c2d_pkg::REG_OUT_WIDTH: ow_q <= cfg_data;
				c2d_pkg::REG_STRIDE: st_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign acc_in = in_valid & in_ready;
	assign pix_acc = acc_in & mode;

	always_comb begin
		col_e = ({1'b0, col_q} >= iw_e) ? 7'(iw_e - 8'd1) : col_q;
		chan_e = ({1'b0, chan_q} >= ic_e) ? 4'(ic_e - 5'd1) : chan_q;
		row_p1 = {1'b0, row_q} + 17'd1;
		col_p1 = {1'b0, col_e} + 8'd1;
		chan_p1 = {1'b0, chan_e} + 5'd1;
		cand = (chan_p1 == ic_e) && (row_p1 >= {13'd0, kh_e}) && (col_p1 >= {4'd0, kw_e});
		dy = 16'(row_p1 - {13'd0, kh_e});
		dx = 7'(col_p1 - {4'd0, kw_e});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			chan_q <= '0;
			wptr_q <= '0;
		end else if (acc_in) begin
			if (!mode) begin
				wptr_q <= last ? 16'd0 : wptr_q + 16'd1;
			end else if (last) begin
				row_q <= '0;
				col_q <= '0;
				chan_q <= '0;
			end else if (chan_p1 >= ic_e) begin
				chan_q <= '0;
				if (col_p1 >= iw_e) begin
					col_q <= '0;
					if (row_q != 16'hFFFF) begin
						row_q <= row_q + 16'd1;
					end
				end else begin
					col_q <= col_p1[6:0];
				end
			end else begin
				chan_q <= chan_p1[3:0];
				col_q <= col_e;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			dy3_q <= dy[2:0];
			dx_q <= dx;
		end
	end

	c2d_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(pix_acc & cand),
		.dvd_y(dy),
		.dvd_x({9'd0, dx}),
		.dvs(st_e),
		.done(div_done),
		.quo_y(q_y),
		.quo_x(q_x),
		.rem_zero_y(rz_y),
		.rem_zero_x(rz_x)
	);

	assign win_ok = rz_y && rz_x && (q_y < {8'd0, oh_e}) && (q_x < {8'd0, ow_e});

	always_comb begin
		last_term = ({1'b0, ci_q} == 5'(ic_e - 5'd1)) && ({1'b0, c_q} == 4'(kw_e - 4'd1)) &&
			({1'b0, r_q} == 4'(kh_e - 4'd1));
		co_last = ({1'b0, co_q} == 7'(oc_e - 7'd1));
		emit_load = (state_q == ST_EMIT) && (!out_vld_q || out_ready);
		lrow = dy3_q + r_q;
		lcol = dx_q + {4'd0, c_q};
		ctl.issue = (state_q == ST_MAC);
		ctl.last_term = last_term;
		ctl.clear = ((state_q == ST_DIV) && div_done) || (emit_load && !co_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			co_q <= '0;
			r_q <= '0;
			c_q <= '0;
			ci_q <= '0;
			waddr_q <= '0;
			final_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pix_acc && cand) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (win_ok) begin
							final_q <= (q_y == 16'({8'd0, oh_e} - 16'd1)) &&
								(q_x == 16'({8'd0, ow_e} - 16'd1));
							co_q <= '0;
							r_q <= '0;
							c_q <= '0;
							ci_q <= '0;
							waddr_q <= '0;
							state_q <= ST_MAC;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_MAC: begin
					waddr_q <= waddr_q + {9'd0, oc_e};
					if (last_term) begin
						state_q <= ST_WAIT;
					end else if ({1'b0, ci_q} == 5'(ic_e - 5'd1)) begin
						ci_q <= '0;
						if ({1'b0, c_q} == 4'(kw_e - 4'd1)) begin
							c_q <= '0;
							r_q <= r_q + 3'd1;
						end else begin
							c_q <= c_q + 3'd1;
						end
					end else begin
						ci_q <= ci_q + 4'd1;
					end
				end
				ST_WAIT: begin
					if (mac_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						if (co_last) begin
							state_q <= ST_IDLE;
						end else begin
							co_q <= co_q + 6'd1;
							waddr_q <= {10'd0, co_q + 6'd1};
							r_q <= '0;
							c_q <= '0;
							ci_q <= '0;
							state_q <= ST_MAC;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	c2d_ram #(.WIDTH(c2d_pkg::VAL_W), .DEPTH(1 << c2d_pkg::WADDR_W)) u_wram (
		.clk(clk),
		.we(acc_in & ~mode),
		.waddr(wptr_q),
		.wdata(value),
		.raddr(waddr_q),
		.rdata(w_rd)
	);

	c2d_ram #(.WIDTH(c2d_pkg::VAL_W), .DEPTH(1 << c2d_pkg::LADDR_W)) u_lram (
		.clk(clk),
		.we(pix_acc),
		.waddr({row_q[2:0], col_e, chan_e}),
		.wdata(value),
		.raddr({lrow, lcol, ci_q}),
		.rdata(l_rd)
	);

	c2d_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.wdata(w_rd),
		.ldata(l_rd),
		.acc(acc),
		.done(mac_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			sum_value <= acc;
			channel <= co_q;
			window_last <= co_last;
			sample_done <= co_last & final_q;
		end
	end

	assign out_valid = out_vld_q;

	`C2D_ASSERT_IMP(a_done_closes_window, out_valid && sample_done, window_last, "Sample end word is not the last channel of its window.")
	`C2D_ASSERT_NXT(a_no_window_stays_ready, pix_acc && !cand, in_ready, "Pixel word without a window left the block busy.")
	`C2D_ASSERT_NXT(a_next_channel_runs, emit_load && !co_last, state_q == ST_MAC, "Next output channel did not start after a word was loaded.")
endmodule
`default_nettype wire

>>> test/conv2d_forward_nhwc_checker.sv
// Checker for the convolution block: predicts each result word and compares it.
`default_nettype none
module conv2d_forward_nhwc_checker (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic                  mode,
	input  wire logic signed [15:0]    value,
	input  wire logic                  last,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic signed [47:0]    sum_value,
	input  wire logic [5:0]            channel,
	input  wire logic                  window_last,
	input  wire logic                  sample_done,
	input  wire logic                  cfg_we,
	input  wire logic [c2d_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [c2d_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                errors,
	output int unsigned                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ROW_SIZE = c2d_pkg::MAX_WIDTH * c2d_pkg::MAX_IN_CHANNELS;

	typedef struct {
		logic signed [47:0] sum;
		logic [5:0]         chan;
		logic               win_end;
		logic               smp_end;
	} conv_sum_t;

	conv_sum_t expected_sums[$];
	logic signed [15:0] weight_mem [0:65535];
	logic signed [15:0] line_mem [0:16383];
	logic [15:0] weight_ptr;
	int unsigned row_pos, col_pos, chan_pos;
	logic [7:0] r_iw, r_oh, r_ow;
	logic [4:0] r_ic;
	logic [3:0] r_kh, r_kw, r_st;
	logic [6:0] r_oc;

	initial errors = 0;
	initial pending = 0;

	function automatic int unsigned fit(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic report(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	task automatic take_pixel(logic signed [15:0] v, logic l);
		int unsigned iw, ic, kh, kw, oc, oh, ow, st, dy, dx, oy, ox, base, k;
		longint acc;
		conv_sum_t e;
		iw = fit(r_iw, c2d_pkg::MAX_WIDTH);
		ic = fit(r_ic, c2d_pkg::MAX_IN_CHANNELS);
		kh = fit(r_kh, c2d_pkg::MAX_KERNEL);
		kw = fit(r_kw, c2d_pkg::MAX_KERNEL);
		oc = fit(r_oc, c2d_pkg::MAX_OUT_CHANNELS);
		oh = fit(r_oh, 65535);
		ow = fit(r_ow, 65535);
		st = fit(r_st, 65535);
		if (col_pos >= iw) col_pos = iw - 1;
		if (chan_pos >= ic) chan_pos = ic - 1;
		line_mem[(row_pos % c2d_pkg::MAX_KERNEL) * ROW_SIZE
			+ col_pos * c2d_pkg::MAX_IN_CHANNELS + chan_pos] = v;
		if (chan_pos == ic - 1 && row_pos + 1 >= kh && col_pos + 1 >= kw) begin
			dy = row_pos + 1 - kh;
			dx = col_pos + 1 - kw;
			oy = dy / st;
			ox = dx / st;
			if (dy % st == 0 && dx % st == 0 && oy < oh && ox < ow) begin
				for (int unsigned co = 0; co < oc; co++) begin
					acc = 0;
					for (int unsigned r = 0; r < kh; r++)
						for (int unsigned c = 0; c < kw; c++) begin
							base = ((dy + r) % c2d_pkg::MAX_KERNEL) * ROW_SIZE
								+ (dx + c) * c2d_pkg::MAX_IN_CHANNELS;
							for (int unsigned ci = 0; ci < ic; ci++) begin
								k = (r * kw + c) * ic + ci;
								acc += longint'(weight_mem[(co + oc * k) % 65536])
									* longint'(line_mem[base + ci]);
							end
						end
					e.sum = acc[47:0];
					e.chan = co[5:0];
					e.win_end = (co == oc - 1);
					e.smp_end = (co == oc - 1) && (oy == oh - 1) && (ox == ow - 1);
					expected_sums.push_back(e);
				end
			end
		end
		chan_pos++;
		if (chan_pos >= ic) begin
			chan_pos = 0;
			col_pos++;
			if (col_pos >= iw) begin
				col_pos = 0;
				if (row_pos < 65535) row_pos++;
			end
		end
		if (l) begin
			row_pos = 0;
			col_pos = 0;
			chan_pos = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		conv_sum_t e;
		if (!arst_n) begin
			expected_sums.delete();
			weight_ptr = '0;
			row_pos = 0;
			col_pos = 0;
			chan_pos = 0;
			r_iw = 8'd1;
			r_ic = 5'd1;
			r_kh = 4'd1;
			r_kw = 4'd1;
			r_oc = 7'd1;
			r_oh = 8'd1;
			r_ow = 8'd1;
			r_st = 4'd1;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_sums.size() == 0) begin
					report($sformatf("unexpected word sum %0d channel %0d", sum_value, channel));
				end else begin
					e = expected_sums.pop_front();
					if (sum_value !== e.sum || channel !== e.chan
						|| window_last !== e.win_end || sample_done !== e.smp_end)
						report($sformatf("got sum %0d ch %0d wl %b sd %b, want %0d %0d %b %b",
							sum_value, channel, window_last, sample_done,
							e.sum, e.chan, e.win_end, e.smp_end));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					c2d_pkg::REG_IN_WIDTH:      r_iw = cfg_data[7:0];
					c2d_pkg::REG_IN_CHANNELS:   r_ic = cfg_data[4:0];
					c2d_pkg::REG_KERNEL_HEIGHT: r_kh = cfg_data[3:0];
					c2d_pkg::REG_KERNEL_WIDTH:  r_kw = cfg_data[3:0];
					c2d_pkg::REG_OUT_CHANNELS:  r_oc = cfg_data[6:0];
					c2d_pkg::REG_OUT_HEIGHT:    r_oh = cfg_data[7:0];
					c2d_pkg::REG_OUT_WIDTH:     r_ow = cfg_data[7:0];
					c2d_pkg::REG_STRIDE:        r_st = cfg_data[3:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (!mode) begin
					weight_mem[weight_ptr] = value;
					weight_ptr = last ? '0 : weight_ptr + 16'd1;
				end else begin
					take_pixel(value, last);
				end
			end
		end
		pending = expected_sums.size();
	end
endmodule
`default_nettype wire

>>> test/tb.sv
// Testbench top for the convolution block: stimulus, idling and the verdict.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef int unsigned reg_set_t [8];

	localparam logic [c2d_pkg::CFG_IDX_W-1:0] REG_ORDER [8] = '{c2d_pkg::REG_IN_WIDTH,
		c2d_pkg::REG_IN_CHANNELS, c2d_pkg::REG_KERNEL_HEIGHT, c2d_pkg::REG_KERNEL_WIDTH,
		c2d_pkg::REG_OUT_CHANNELS, c2d_pkg::REG_OUT_HEIGHT, c2d_pkg::REG_OUT_WIDTH,
		c2d_pkg::REG_STRIDE};
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned ITEM_TARGET = 130;

	logic clk, arst_n, in_valid, in_ready, mode, last;
	logic out_valid, out_ready, window_last, sample_done, cfg_we;
	logic signed [15:0] value;
	logic signed [47:0] sum_value;
	logic [5:0] channel;
	logic [c2d_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [c2d_pkg::CFG_DATA_W-1:0] cfg_data;
	int unsigned errors, pending;
	int unsigned words_in = 0, sums_out = 0, cycles = 0;
	bit long_hold_done = 0;

	conv2d_forward_nhwc i_dut (.*);
	conv2d_forward_nhwc_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (in_valid && in_ready) words_in <= words_in + 1;
		if (out_valid && out_ready) sums_out <= sums_out + 1;
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [15:0] rand_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'sh7fff;
		if (r == 1) return 16'sh8000;
		return 16'($urandom());
	endfunction

	function automatic int unsigned fit(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic send_word(logic m, logic signed [15:0] v, logic l);
		int unsigned g, target;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		mode <= m;
		value <= v;
		last <= l;
		in_valid <= 1'b1;
		target = words_in + 1;
		while (words_in < target) @(negedge clk);
	endtask

	task automatic load_weights(int unsigned n);
		for (int unsigned i = 0; i < n; i++) send_word(1'b0, rand_value(), i == n - 1);
	endtask

	task automatic send_sample(int unsigned rows, int unsigned iw, int unsigned ic, bit noisy);
		int unsigned total;
		total = rows * iw * ic;
		if (noisy && $urandom_range(0, 3) == 0) total = $urandom_range(1, total);
		for (int unsigned i = 0; i < total; i++) begin
			if (noisy && $urandom_range(0, 49) == 0) send_word(1'b0, rand_value(), 1'b1);
			send_word(1'b1, rand_value(), i == total - 1);
		end
	endtask

	task automatic run_phase(reg_set_t raw, int unsigned rows, int unsigned samples, bit noisy);
		int unsigned iw, ic, nweights;
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (64) @(negedge clk);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_data <= raw[i][c2d_pkg::CFG_DATA_W-1:0];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		iw = fit(raw[0], c2d_pkg::MAX_WIDTH);
		ic = fit(raw[1], c2d_pkg::MAX_IN_CHANNELS);
		nweights = ic * fit(raw[2], c2d_pkg::MAX_KERNEL) * fit(raw[3], c2d_pkg::MAX_KERNEL)
			* fit(raw[4], c2d_pkg::MAX_OUT_CHANNELS);
		if (noisy && $urandom_range(0, 2) == 0) load_weights($urandom_range(1, nweights));
		load_weights(nweights);
		for (int unsigned s = 0; s < samples; s++) send_sample(rows, iw, ic, noisy);
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && sums_out >= 70) begin
				out_ready <= 1'b0;
				repeat (600) @(negedge clk);
				long_hold_done = 1;
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
				begin
					int unsigned g;
					g = gap_len();
					if (g > 0) begin
						out_ready <= 1'b0;
						repeat (g - 1) @(negedge clk);
					end
				end
			end
		end
	end

	initial begin
		int unsigned kh, kw, st, oh, ow, ic, oc, iw, rows;
		reg_set_t raw;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = 1'b0;
		value = '0;
		last = 1'b0;
		cfg_we = 1'b0;
		cfg_index = c2d_pkg::REG_IN_WIDTH;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(1'b0, 16'sh8000, 1'b1);
		send_word(1'b1, 16'sh8000, 1'b0);
		send_word(1'b1, 16'sh7fff, 1'b0);
		send_word(1'b1, 16'sh7fff, 1'b1);
		run_phase(reg_set_t'{2, 1, 1, 1, 127, 2, 2, 0}, 2, 1, 0);
		run_phase(reg_set_t'{1, 1, 15, 1, 1, 1, 1, 1}, 8, 1, 0);
		run_phase(reg_set_t'{1, 31, 1, 1, 1, 0, 0, 1}, 1, 1, 0);
		run_phase(reg_set_t'{1, 1, 1, 1, 1, 255, 255, 15}, 2, 1, 0);

		do begin
			kh = $urandom_range(1, 3);
			kw = $urandom_range(1, 3);
			st = $urandom_range(1, 2);
			oh = $urandom_range(1, 2);
			ow = $urandom_range(1, 3);
			ic = $urandom_range(1, 3);
			oc = $urandom_range(1, 4);
			iw = (ow - 1) * st + kw + $urandom_range(0, 1);
			rows = (oh - 1) * st + kh + $urandom_range(0, 1);
			raw = '{iw, ic, kh, kw, oc, oh, ow, st};
			for (int i = 0; i < 8; i++)
				if (raw[i] == 1 && $urandom_range(0, 2) == 0) raw[i] = 0;
			run_phase(raw, rows, $urandom_range(1, 2), 1);
		end while (words_in < ITEM_TARGET);

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/c2d_pkg.sv
rtl/c2d_ram.sv
rtl/c2d_div.sv
rtl/c2d_mac.sv
rtl/conv2d_forward_nhwc.sv
test/conv2d_forward_nhwc_checker.sv
test/tb.sv
